// File: rtl/epps_pkg.sv
// shared constants, codes and controller/datapath interface types
`default_nettype none

package epps_pkg;

    localparam int TABLE_DEPTH  = 65536;
    localparam int VALUE_BITS   = 32;
    localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = 32;
    localparam int STATUS_BITS  = 2;

    localparam logic [VALUE_BITS-1:0] START_EVEN_RST = VALUE_BITS'(4);
    localparam logic [CNT_BITS-1:0]   DEPTH_CNT      = CNT_BITS'(TABLE_DEPTH);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_EVEN  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_COUNT = CFG_IDX_BITS'(1);

    localparam logic [STATUS_BITS-1:0] STATUS_FOUND  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOPAIR = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_SHORT  = 2'd2;

    typedef struct packed {
        logic                   wr_en;
        logic                   cfg_we;
        logic                   walk_start;
        logic                   ui_inc;
        logic                   set_ready;
        logic                   even_inc;
        logic                   srch_init;
        logic                   lo_inc;
        logic                   hi_dec;
        logic                   rd_upper;
        logic                   res_load;
        logic [STATUS_BITS-1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic index_ready;
        logic cnt_short;
        logic below;
        logic ptr_ok;
        logic sum_eq;
        logic sum_lt;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/epps_ram.sv
// generic single write port ram with registered read
`default_nettype none

module epps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/epps_datapath.sv
// prime table copies, pointers, running even number and result registers
`default_nettype none

module epps_datapath
    import epps_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_stat                        o_stat,
    input  wire logic [IDX_BITS-1:0]     i_entry_index,
    input  wire logic [VALUE_BITS-1:0]   i_prime_value,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data,
    output logic      [VALUE_BITS-1:0]   o_even_value,
    output logic      [VALUE_BITS-1:0]   o_low_prime,
    output logic      [VALUE_BITS-1:0]   o_high_prime,
    output logic      [STATUS_BITS-1:0]  o_status
);

    logic [VALUE_BITS-1:0]  r_cur_even;
    logic [CNT_BITS-1:0]    r_prime_count;
    logic                   r_index_ready;
    logic [IDX_BITS-1:0]    r_upper_idx;
    logic [CNT_BITS-1:0]    r_lo;
    logic [IDX_BITS-1:0]    r_hi;
    logic [VALUE_BITS-1:0]  r_res_even;
    logic [VALUE_BITS-1:0]  r_res_lo;
    logic [VALUE_BITS-1:0]  r_res_hi;
    logic [STATUS_BITS-1:0] r_res_status;

    logic [CNT_BITS-1:0]   upper_next;
    logic [CNT_BITS-1:0]   valid_cnt;
    logic [IDX_BITS-1:0]   raddr_a;
    logic [VALUE_BITS-1:0] rdata_a;
    logic [VALUE_BITS-1:0] rdata_b;
    logic [VALUE_BITS:0]   pair_sum;

    assign upper_next = {1'b0, r_upper_idx} + CNT_BITS'(1);
    assign valid_cnt  = (r_prime_count > DEPTH_CNT) ? DEPTH_CNT : r_prime_count;
    assign raddr_a    = i_cmd.rd_upper ? upper_next[IDX_BITS-1:0] : r_lo[IDX_BITS-1:0];
    assign pair_sum   = {1'b0, rdata_a} + {1'b0, rdata_b};

    // low pointer copy
    epps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_entry_index),
        .i_wdata (i_prime_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    // high pointer copy
    epps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_entry_index),
        .i_wdata (i_prime_value),
        .i_raddr (r_hi),
        .o_rdata (rdata_b)
    );

    always_comb begin
        o_stat.index_ready = r_index_ready;
        o_stat.cnt_short   = (upper_next >= valid_cnt);
        o_stat.below       = (r_cur_even != '0) && (rdata_a < (r_cur_even - VALUE_BITS'(1)));
        o_stat.ptr_ok      = (r_lo <= {1'b0, r_hi});
        o_stat.sum_eq      = (pair_sum == {1'b0, r_cur_even});
        o_stat.sum_lt      = (pair_sum < {1'b0, r_cur_even});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_even    <= START_EVEN_RST;
            r_prime_count <= '0;
            r_index_ready <= 1'b0;
            r_upper_idx   <= '0;
        end else begin
            if (i_cmd.cfg_we) begin
                case (i_cfg_index)
                    CFG_START_EVEN: begin
                        if (!r_index_ready) begin
                            r_cur_even <= i_cfg_data[VALUE_BITS-1:0];
                        end
                    end
                    CFG_PRIME_COUNT: begin
                        r_prime_count <= i_cfg_data[CNT_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.even_inc) begin
                r_cur_even <= r_cur_even + VALUE_BITS'(2);
            end
            if (i_cmd.set_ready) begin
                r_index_ready <= 1'b1;
            end
            if (i_cmd.walk_start) begin
                r_upper_idx <= '0;
            end else if (i_cmd.ui_inc) begin
                r_upper_idx <= upper_next[IDX_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_lo <= CNT_BITS'(1);
            r_hi <= r_upper_idx;
        end else begin
            if (i_cmd.lo_inc) begin
                r_lo <= r_lo + CNT_BITS'(1);
            end
            if (i_cmd.hi_dec) begin
                r_hi <= r_hi - IDX_BITS'(1);
            end
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            if (i_cmd.even_inc) begin
                r_res_even <= r_cur_even + VALUE_BITS'(2);
            end else begin
                r_res_even <= r_cur_even;
            end
            if (i_cmd.res_status == STATUS_FOUND) begin
                r_res_lo <= rdata_a;
                r_res_hi <= rdata_b;
            end else begin
                r_res_lo <= '0;
                r_res_hi <= '0;
            end
        end
    end

    assign o_even_value = r_res_even;
    assign o_low_prime  = r_res_lo;
    assign o_high_prime = r_res_hi;
    assign o_status     = r_res_status;

endmodule

`default_nettype wire

// File: rtl/epps_ctrl.sv
// sequencing state machine and result valid flag
`default_nettype none

module epps_ctrl
    import epps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_operation,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    input  wire logic  i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_WALK_RD   = 4'd1;
    localparam logic [3:0] S_WALK_CMP  = 4'd2;
    localparam logic [3:0] S_ADV_RD    = 4'd3;
    localparam logic [3:0] S_ADV_CMP   = 4'd4;
    localparam logic [3:0] S_SHORT     = 4'd5;
    localparam logic [3:0] S_SRCH_INIT = 4'd6;
    localparam logic [3:0] S_SRCH_RD   = 4'd7;
    localparam logic [3:0] S_SRCH_CMP  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_xfer;
    logic       out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rd_upper   = 1'b1;
        o_cmd.res_status = STATUS_FOUND;
        o_cmd.wr_en      = in_xfer && (i_operation == OP_WRITE);
        o_cmd.cfg_we     = i_cfg_valid && o_cfg_ready;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_operation == OP_CHECK)) begin
                    if (i_stat.index_ready) begin
                        n_state = S_ADV_RD;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                if (i_stat.cnt_short) begin
                    n_state = S_SHORT;
                end else begin
                    n_state = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_stat.below) begin
                    o_cmd.ui_inc = 1'b1;
                    n_state      = S_WALK_RD;
                end else begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = S_ADV_RD;
                end
            end
            S_ADV_RD: begin
                if (i_stat.cnt_short) begin
                    n_state = S_SHORT;
                end else begin
                    o_cmd.even_inc = 1'b1;
                    n_state        = S_ADV_CMP;
                end
            end
            S_ADV_CMP: begin
                o_cmd.ui_inc = i_stat.below;
                n_state      = S_SRCH_INIT;
            end
            S_SHORT: begin
                if (out_free) begin
                    o_cmd.even_inc   = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STATUS_SHORT;
                    n_state          = S_IDLE;
                end
            end
            S_SRCH_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_state         = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                o_cmd.rd_upper = 1'b0;
                if (i_stat.ptr_ok) begin
                    n_state = S_SRCH_CMP;
                end else if (out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STATUS_NOPAIR;
                    n_state          = S_IDLE;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.rd_upper = 1'b0;
                if (i_stat.sum_eq) begin
                    if (out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = STATUS_FOUND;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.sum_lt) begin
                    o_cmd.lo_inc = 1'b1;
                    n_state      = S_SRCH_RD;
                end else begin
                    o_cmd.hi_dec = 1'b1;
                    n_state      = S_SRCH_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/even_prime_pair_search_top.sv
// even_prime_pair_search top level: controller, datapath and checks
//
// A write item stores one prime into the table and gives no result. A check item adds 2 to
// the running even number, may move the upper index and, unless the table is too short, runs
// the two-pointer search, giving one result. The table is held twice, one copy per pointer,
// each with one read port and a registered read, so every table lookup has an address state
// followed by a compare state. Until the upper index has been found, a check first walks the
// table from entry 0 to find it; a walk that runs off the end of the table, or a table too
// short for the next upper index, gives the short status without a search. Otherwise the
// search moves the low or high pointer each step until a pair is found or the pointers cross.
// A finished result sits in an output register, so the next item is taken while it waits; the
// block stalls before loading a new result only if the previous one has not been transferred.
// Configuration is accepted whenever no check is in progress.
`default_nettype none

module even_prime_pair_search_top
    import epps_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_operation,
    input  wire logic [IDX_BITS-1:0]     i_entry_index,
    input  wire logic [VALUE_BITS-1:0]   i_prime_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic      [VALUE_BITS-1:0]   o_even_value,
    output logic      [VALUE_BITS-1:0]   o_low_prime,
    output logic      [VALUE_BITS-1:0]   o_high_prime,
    output logic      [STATUS_BITS-1:0]  o_status,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_BITS-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    epps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    epps_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_entry_index (i_entry_index),
        .i_prime_value (i_prime_value),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_even_value  (o_even_value),
        .o_low_prime   (o_low_prime),
        .o_high_prime  (o_high_prime),
        .o_status      (o_status)
    );

`ifndef SYNTHESIS
    // a failed check carries no primes
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STATUS_FOUND)) |->
            ((o_low_prime == '0) && (o_high_prime == '0)))
        else $error("failed check reports nonzero primes");

    // a found pair sums to the even number
    a_pair_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_FOUND)) |->
            (({1'b0, o_low_prime} + {1'b0, o_high_prime}) == {1'b0, o_even_value}))
        else $error("found pair does not sum to even value");

    // a table write keeps the block ready for the next transfer
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_operation == OP_WRITE)) |=> !o_in_stall)
        else $error("table write stalled the input");

    // a check transfer leaves the block busy, stalling input and configuration
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_operation == OP_CHECK)) |=> (o_in_stall && !o_cfg_ready))
        else $error("check transfer did not start a search");
`endif

endmodule

`default_nettype wire

// File: test/even_prime_pair_search_top_test.sv
// self-checking testbench for the even prime pair search block: directed table, then random phases
`default_nettype none

module even_prime_pair_search_top_test;
    import epps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PRIMES     = 200;
    localparam int RANDOM_ITEMS   = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_DRAIN      = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 10000;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  even;
        logic [VALUE_BITS-1:0]  lo;
        logic [VALUE_BITS-1:0]  hi;
        logic [STATUS_BITS-1:0] status;
    } t_pair_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic                    op;
        logic [IDX_BITS-1:0]     idx;
        logic [CFG_IDX_BITS-1:0] reg_sel;
        logic [CFG_BITS-1:0]     data;
        bit                      typed;
        t_pair_res               res;
    } t_dir_row;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    i_operation   = OP_WRITE;
    logic [IDX_BITS-1:0]     i_entry_index = '0;
    logic [VALUE_BITS-1:0]   i_prime_value = '0;
    logic                    i_out_stall   = 1'b0;
    logic                    i_cfg_valid   = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index   = CFG_START_EVEN;
    logic [CFG_BITS-1:0]     i_cfg_data    = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [VALUE_BITS-1:0]   o_even_value;
    logic [VALUE_BITS-1:0]   o_low_prime;
    logic [VALUE_BITS-1:0]   o_high_prime;
    logic [STATUS_BITS-1:0]  o_status;
    logic                    o_cfg_ready;

    even_prime_pair_search_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_prime_value (i_prime_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_even_value  (o_even_value),
        .o_low_prime   (o_low_prime),
        .o_high_prime  (o_high_prime),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [VALUE_BITS-1:0] prime_mem [TABLE_DEPTH];
    logic [CNT_BITS-1:0]   m_prime_count = '0;
    logic [VALUE_BITS-1:0] m_even = START_EVEN_RST;
    int                    m_upper = 0;
    bit                    m_ready = 1'b0;

    t_pair_res pending_pairs[$];
    t_dir_row  dir_rows[$];
    int        primes[NUM_PRIMES];
    int        err_count   = 0;
    int        items_sent  = 0;
    int        hold_req    = 0;
    int        hold_served = 0;
    bit        gaps_on     = 1'b1;

    function automatic bit below_even_minus_one(logic [VALUE_BITS-1:0] p,
                                                logic [VALUE_BITS-1:0] e);
        return (e != '0) && (p < e - 1);
    endfunction

    function automatic void model_cfg(logic [CFG_IDX_BITS-1:0] sel, logic [CFG_BITS-1:0] data);
        if (sel == CFG_START_EVEN) begin
            if (!m_ready)
                m_even = data;
        end else begin
            m_prime_count = data[CNT_BITS-1:0];
        end
    endfunction

    function automatic void model_item(logic op, logic [IDX_BITS-1:0] idx,
                                       logic [VALUE_BITS-1:0] val,
                                       output bit has_res, output t_pair_res r);
        int                  cnt;
        int                  walk;
        int                  lo;
        int                  hi;
        bit                  short_tbl;
        logic [VALUE_BITS:0] sum;
        has_res   = 1'b0;
        r         = '0;
        short_tbl = 1'b0;
        if (op == OP_WRITE) begin
            prime_mem[idx] = val;
            return;
        end
        cnt = (m_prime_count > DEPTH_CNT) ? TABLE_DEPTH : int'(m_prime_count);
        if (!m_ready) begin
            walk = 0;
            forever begin
                if (walk + 1 >= cnt) begin
                    short_tbl = 1'b1;
                    break;
                end
                if (!below_even_minus_one(prime_mem[walk+1], m_even))
                    break;
                walk++;
            end
            if (!short_tbl) begin
                m_upper = walk;
                m_ready = 1'b1;
            end
        end
        m_even = m_even + 2;
        if (!short_tbl) begin
            if (m_upper + 1 >= cnt)
                short_tbl = 1'b1;
            else if (below_even_minus_one(prime_mem[m_upper+1], m_even))
                m_upper++;
        end
        has_res = 1'b1;
        r.even  = m_even;
        if (short_tbl) begin
            r.status = STATUS_SHORT;
        end else begin
            r.status = STATUS_NOPAIR;
            lo = 1;
            hi = m_upper;
            while (lo <= hi) begin
                sum = {1'b0, prime_mem[lo]} + {1'b0, prime_mem[hi]};
                if (sum == {1'b0, m_even}) begin
                    r.status = STATUS_FOUND;
                    r.lo     = prime_mem[lo];
                    r.hi     = prime_mem[hi];
                    break;
                end
                if (sum < {1'b0, m_even})
                    lo++;
                else
                    hi--;
            end
        end
    endfunction

    function automatic t_pair_res too_short_result(logic [VALUE_BITS-1:0] e);
        t_pair_res r;
        r        = '0;
        r.even   = e;
        r.status = STATUS_SHORT;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void row_check(bit typed, t_pair_res res);
        t_dir_row row;
        row = '{kind: ROW_ITEM, op: OP_CHECK, idx: '0, reg_sel: CFG_START_EVEN, data: '0,
                typed: typed, res: res};
        dir_rows.push_back(row);
    endfunction

    function automatic void row_write(int idx, logic [VALUE_BITS-1:0] val);
        t_dir_row row;
        row = '{kind: ROW_ITEM, op: OP_WRITE, idx: idx[IDX_BITS-1:0], reg_sel: CFG_START_EVEN,
                data: val, typed: 1'b0, res: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_BITS-1:0] sel, logic [CFG_BITS-1:0] data);
        t_dir_row row;
        row = '{kind: ROW_CFG, op: OP_WRITE, idx: '0, reg_sel: sel, data: data,
                typed: 1'b0, res: '0};
        dir_rows.push_back(row);
    endfunction

    task automatic send_item(logic op, logic [IDX_BITS-1:0] idx, logic [VALUE_BITS-1:0] val,
                             bit typed, t_pair_res typed_res);
        int        gap;
        bit        has_res;
        t_pair_res r;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_prime_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        model_item(op, idx, val, has_res, r);
        if (has_res)
            pending_pairs.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] sel, logic [CFG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_cfg(sel, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stalls, with a long hold-off on request
    always @(posedge i_clk) begin
        static int  run_left = 0;
        static bit  stalling = 1'b0;
        if (hold_served != hold_req) begin
            hold_served = hold_req;
            run_left    = HOLD_CYCLES;
            stalling    = 1'b1;
        end
        if (run_left == 0) begin
            stalling = ($urandom_range(0, 2) == 0);
            if (stalling)
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
            else
                run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                       : $urandom_range(1, 6);
        end
        run_left--;
        i_out_stall <= stalling;
    end

    always @(posedge i_clk) begin
        t_pair_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t: result with no pending check, even_value %0d", $time,
                         o_even_value);
                err_count++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_even_value !== want.even) begin
                    $display("%0t: even_value expected %0d actual %0d", $time, want.even,
                             o_even_value);
                    err_count++;
                end
                if (o_low_prime !== want.lo) begin
                    $display("%0t: low_prime expected %0d actual %0d", $time, want.lo,
                             o_low_prime);
                    err_count++;
                end
                if (o_high_prime !== want.hi) begin
                    $display("%0t: high_prime expected %0d actual %0d", $time, want.hi,
                             o_high_prime);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_status);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        static int idle_cycles = 0;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int        cand;
        int        found;
        int        k;
        bit        is_prime;
        int        tbl_len;
        int        rand_base;
        int        phase;
        int        n;
        int        r;
        int        j;
        int        perturbed[$];
        logic [VALUE_BITS-1:0] v;

        found = 0;
        cand  = 2;
        while (found < NUM_PRIMES) begin
            is_prime = 1'b1;
            for (k = 2; k * k <= cand; k++)
                if (cand % k == 0)
                    is_prime = 1'b0;
            if (is_prime) begin
                primes[found] = cand;
                found++;
            end
            cand++;
        end

        // directed stimulus
        row_check(1'b1, too_short_result(32'd6));
        row_cfg(CFG_START_EVEN, 32'hFFFF_FFFE);
        row_check(1'b1, too_short_result(32'd0));
        row_cfg(CFG_START_EVEN, 32'd5);
        row_check(1'b1, too_short_result(32'd7));
        row_write(TABLE_DEPTH - 1, 32'hFFFF_FFFF);
        for (k = 0; k < 8; k++)
            row_write(k, primes[k]);
        row_cfg(CFG_PRIME_COUNT, 32'd8);
        row_cfg(CFG_START_EVEN, 32'd30);
        row_check(1'b1, too_short_result(32'd32));
        row_cfg(CFG_START_EVEN, 32'd4);
        repeat (3) row_check(1'b0, '0);
        row_write(2, 32'd9);
        row_check(1'b0, '0);
        row_write(2, primes[2]);
        row_cfg(CFG_PRIME_COUNT, 32'h1FFFF);
        repeat (2) row_check(1'b0, '0);
        row_cfg(CFG_PRIME_COUNT, 32'd8);
        repeat (3) row_check(1'b0, '0);
        row_check(1'b1, too_short_result(32'd24));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(dir_rows[i].reg_sel, dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].data,
                          dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // random phases: table grows ahead of the running even number
        tbl_len   = 8;
        rand_base = items_sent;
        phase     = 0;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 9) == 0)
                cfg_write(CFG_PRIME_COUNT, tbl_len - $urandom_range(1, 3));
            else
                cfg_write(CFG_PRIME_COUNT, tbl_len);
            if ($urandom_range(0, 5) == 0)
                cfg_write(CFG_START_EVEN, ($urandom & 32'hFFFF_FFFE) | 32'd4);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 3 || phase == 12)
                hold_req++;
            n = $urandom_range(10, 30);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (tbl_len < NUM_PRIMES &&
                    (primes[tbl_len-1] < m_even + 60 ||
                     (primes[tbl_len-1] < m_even + 150 && r < 30))) begin
                    send_item(OP_WRITE, IDX_BITS'(tbl_len), primes[tbl_len], 1'b0, '0);
                    tbl_len++;
                end else if (r < 40) begin
                    send_item(OP_WRITE, IDX_BITS'($urandom_range(tbl_len, TABLE_DEPTH - 1)),
                              $urandom, 1'b0, '0);
                end else if (r < 44) begin
                    j = $urandom_range(1, tbl_len - 1);
                    v = $urandom_range(0, 1) ? $urandom : primes[j] + 2 * $urandom_range(1, 3);
                    perturbed.push_back(j);
                    send_item(OP_WRITE, IDX_BITS'(j), v, 1'b0, '0);
                end else if (r < 52 && perturbed.size() > 0) begin
                    j = perturbed.pop_front();
                    send_item(OP_WRITE, IDX_BITS'(j), primes[j], 1'b0, '0);
                end else begin
                    send_item(OP_CHECK, IDX_BITS'($urandom), $urandom, 1'b0, '0);
                end
            end
            phase++;
        end

        wait_idle();
        repeat (END_DRAIN) @(posedge i_clk);
        if (err_count == 0 && pending_pairs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/epps_pkg.sv
rtl/epps_ram.sv
rtl/epps_datapath.sv
rtl/epps_ctrl.sv
rtl/even_prime_pair_search_top.sv
test/even_prime_pair_search_top_test.sv
